FILE: rtl/ppu_pkg.sv
`default_nettype none

package ppu_pkg;

  // Fixed formats of the payload and configuration words
  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;

  // Action codes
  localparam logic ACT_PROJECT   = 1'b0;
  localparam logic ACT_UNPROJECT = 1'b1;

  // Configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FOCAL,
    REG_CENTER,
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_TRANS_X,
    REG_TRANS_Y,
    REG_TRANS_Z
  } cfg_reg_e;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } pp_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         div_error;
  } pp_out_t;

endpackage

`default_nettype wire

FILE: rtl/pinhole_project_unproject.sv
`default_nettype none

// Pinhole camera projection / back-projection with a rigid transform. Each input word either
// projects a world point to a pixel (camera point R^T(p - t), u = x*fx/z + cx, v = y*fy/z + cy,
// depth z) or back-projects a pixel with depth to a world point (R*cam + t). All values are
// fixed point, products and quotients truncate toward zero and results saturate; a non-positive
// camera depth or a zero focal length raises div_error and forces out_x and out_y to the most
// positive value. The pipeline takes one word per clock while in_stall_o is low. The restoring
// divider resolves one quotient bit per stage for an NW-bit dividend, where NW = 71 with the
// default ROT_BITS. A two-word output buffer separates the two handshakes, so in_stall_o
// rises only when that buffer is full. Configuration registers should be written only while
// the block is idle; the block itself does not enforce this, and cfg_ready_o is always high.
module pinhole_project_unproject #(
  parameter int ROT_BITS = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ppu_pkg::pp_in_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ppu_pkg::pp_out_t                    out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppu_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ppu_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  import ppu_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int RB   = ROT_BITS;
  localparam int DDW  = CB + 1;
  localparam int EW   = ((CB > 32) ? CB : 33) + 1;
  localparam int PAW  = RB + DDW;
  localparam int TAW  = PAW - FRAC_BITS + 1;
  localparam int CAMW = TAW + 2;
  localparam int MAW  = (CAMW > EW) ? CAMW : EW;
  localparam int MBW  = (CB > 33) ? CB : 33;
  localparam int NW   = MAW + MBW;
  localparam int DW   = (CAMW > 32) ? CAMW : 32;
  localparam int QB   = CB + 33;
  localparam int PBW  = RB + CB;
  localparam int TBW  = PBW - FRAC_BITS + 1;
  localparam int ACW  = ((TBW > CB) ? TBW : CB) + 2;
  localparam int SW1  = ((QB + 3) > ACW) ? (QB + 3) : ACW;
  localparam int SATW = (SW1 > CAMW) ? SW1 : CAMW;

  localparam logic [3*RB-1:0]        ROT_ONE = (3*RB)'(1) << FRAC_BITS;
  localparam logic signed [CB-1:0]   CMAX    = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [SATW-1:0] SMAX    = SATW'({1'b0, {(CB-1){1'b1}}});
  localparam logic signed [SATW-1:0] SMIN    = ~SMAX;

  function automatic logic signed [CB-1:0] sat_cb(input logic signed [SATW-1:0] x);
    logic signed [CB-1:0] r;
    if (x > SMAX) begin
      r = CMAX;
    end else if (x < SMIN) begin
      r = CB'(SMIN);
    end else begin
      r = CB'(x);
    end
    return r;
  endfunction

  function automatic logic signed [TAW-1:0] term_a(input logic [PAW-1:0] mag, input logic neg);
    logic signed [TAW-1:0] t;
    t = $signed({1'b0, mag[PAW-1:FRAC_BITS]});
    return neg ? -t : t;
  endfunction

  function automatic logic signed [TBW-1:0] term_b(input logic [PBW-1:0] mag, input logic neg);
    logic signed [TBW-1:0] t;
    t = $signed({1'b0, mag[PBW-1:FRAC_BITS]});
    return neg ? -t : t;
  endfunction

  function automatic logic [QB-1:0] clamp_q(input logic [NW-1:0] q);
    logic ovf;
    ovf = |(q >> QB);
    return ovf ? {QB{1'b1}} : QB'(q);
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [31:0]          fx_q, fy_q, cx_q, cy_q;
  logic [3*RB-1:0]      rot_q [3];
  logic signed [CB-1:0] tr_q [3];
  logic signed [RB-1:0] rm [3][3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q     <= '0;
      fy_q     <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      rot_q[0] <= ROT_ONE;
      rot_q[1] <= ROT_ONE << RB;
      rot_q[2] <= ROT_ONE << (2 * RB);
      tr_q[0]  <= '0;
      tr_q[1]  <= '0;
      tr_q[2]  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FOCAL: begin
          fx_q <= cfg_data_i[31:0];
          fy_q <= cfg_data_i[63:32];
        end
        REG_CENTER: begin
          cx_q <= cfg_data_i[31:0];
          cy_q <= cfg_data_i[63:32];
        end
        REG_ROT0:    rot_q[0] <= cfg_data_i[3*RB-1:0];
        REG_ROT1:    rot_q[1] <= cfg_data_i[3*RB-1:0];
        REG_ROT2:    rot_q[2] <= cfg_data_i[3*RB-1:0];
        REG_TRANS_X: tr_q[0]  <= cfg_data_i[CB-1:0];
        REG_TRANS_Y: tr_q[1]  <= cfg_data_i[CB-1:0];
        REG_TRANS_Z: tr_q[2]  <= cfg_data_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // Unpack rotation entries
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rm[r][c] = rot_q[r][c*RB +: RB];
      end
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [1:0] cnt_q;
  logic       en;
  logic       push;
  logic       pop;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage 1: offsets
  logic signed [CB-1:0]  pin [3];
  logic                  v1_q, act1_q;
  logic signed [DDW-1:0] d1_q [3];
  logic signed [EW-1:0]  ex1_q, ey1_q;
  logic signed [CB-1:0]  z1_q;

  assign pin[0] = in_data_i.coord_x;
  assign pin[1] = in_data_i.coord_y;
  assign pin[2] = in_data_i.coord_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q <= in_data_i.action;
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DDW'(pin[i]) - DDW'(tr_q[i]);
      end
      ex1_q <= EW'(pin[0]) - EW'($signed({1'b0, cx_q}));
      ey1_q <= EW'(pin[1]) - EW'($signed({1'b0, cy_q}));
      z1_q  <= pin[2];
    end
  end

  // ---------------------------------------------------------------- stages 2-3: R^T products
  logic [PAW-1:0] pa_mag [3][3];
  logic           pa_neg [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_mula_r
    for (genvar j = 0; j < 3; j++) begin : g_mula_c
      ppu_mul #(.AW(RB), .BW(DDW)) u_mula (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (rm[i][j]),
        .b_i   (d1_q[i]),
        .mag_o (pa_mag[i][j]),
        .neg_o (pa_neg[i][j])
      );
    end
  end

  logic                 v2_q, v3_q, act2_q, act3_q;
  logic signed [EW-1:0] ex2_q, ey2_q, ex3_q, ey3_q;
  logic signed [CB-1:0] z2_q, z3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act2_q <= act1_q;
      ex2_q  <= ex1_q;
      ey2_q  <= ey1_q;
      z2_q   <= z1_q;
      act3_q <= act2_q;
      ex3_q  <= ex2_q;
      ey3_q  <= ey2_q;
      z3_q   <= z2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: camera point
  logic                   v4_q, act4_q;
  logic signed [CAMW-1:0] cam4_q [3];
  logic signed [EW-1:0]   ex4_q, ey4_q;
  logic signed [CB-1:0]   z4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        cam4_q[j] <= CAMW'(term_a(pa_mag[0][j], pa_neg[0][j]))
                   + CAMW'(term_a(pa_mag[1][j], pa_neg[1][j]))
                   + CAMW'(term_a(pa_mag[2][j], pa_neg[2][j]));
      end
      act4_q <= act3_q;
      ex4_q  <= ex3_q;
      ey4_q  <= ey3_q;
      z4_q   <= z3_q;
    end
  end

  // Pick dividend factors and divisors, flag bad depth or focal length
  logic                  err4;
  logic signed [MAW-1:0] ax4, ay4;
  logic signed [MBW-1:0] bx4, by4;
  logic [DW-1:0]         denx4, deny4;
  logic signed [CB-1:0]  zsel4;

  always_comb begin
    if (act4_q == ACT_UNPROJECT) begin
      err4  = (z4_q <= 0) || (fx_q == '0) || (fy_q == '0);
      ax4   = MAW'(ex4_q);
      ay4   = MAW'(ey4_q);
      bx4   = MBW'(z4_q);
      by4   = MBW'(z4_q);
      denx4 = DW'(fx_q);
      deny4 = DW'(fy_q);
      zsel4 = z4_q;
    end else begin
      err4  = (cam4_q[2] <= 0) || (fx_q == '0) || (fy_q == '0);
      ax4   = MAW'(cam4_q[0]);
      ay4   = MAW'(cam4_q[1]);
      bx4   = MBW'($signed({1'b0, fx_q}));
      by4   = MBW'($signed({1'b0, fy_q}));
      denx4 = DW'($unsigned(cam4_q[2]));
      deny4 = DW'($unsigned(cam4_q[2]));
      zsel4 = sat_cb(SATW'(cam4_q[2]));
    end
  end

  // ---------------------------------------------------------------- stages 5-6: dividends
  logic [NW-1:0] mbx_mag, mby_mag;
  logic          mbx_neg, mby_neg;

  ppu_mul #(.AW(MAW), .BW(MBW)) u_mulbx (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ax4),
    .b_i   (bx4),
    .mag_o (mbx_mag),
    .neg_o (mbx_neg)
  );

  ppu_mul #(.AW(MAW), .BW(MBW)) u_mulby (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ay4),
    .b_i   (by4),
    .mag_o (mby_mag),
    .neg_o (mby_neg)
  );

  logic                 v5_q, v6_q, act5_q, act6_q, err5_q, err6_q;
  logic signed [CB-1:0] z5_q, z6_q;
  logic [DW-1:0]        denx5_q, deny5_q, denx6_q, deny6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act5_q  <= act4_q;
      err5_q  <= err4;
      z5_q    <= zsel4;
      denx5_q <= denx4;
      deny5_q <= deny4;
      act6_q  <= act5_q;
      err6_q  <= err5_q;
      z6_q    <= z5_q;
      denx6_q <= denx5_q;
      deny6_q <= deny5_q;
    end
  end

  // ---------------------------------------------------------------- divider stages
  logic [NW-1:0] qx, qy;

  ppu_div #(.NW(NW), .DW(DW)) u_divx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mbx_mag),
    .den_i (denx6_q),
    .quo_o (qx)
  );

  ppu_div #(.NW(NW), .DW(DW)) u_divy (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mby_mag),
    .den_i (deny6_q),
    .quo_o (qy)
  );

  logic [NW-1:0]        dv_q, dact_q, derr_q, dnx_q, dny_q;
  logic signed [CB-1:0] dz_q [NW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dact_q <= {dact_q[NW-2:0], act6_q};
      derr_q <= {derr_q[NW-2:0], err6_q};
      dnx_q  <= {dnx_q[NW-2:0], mbx_neg};
      dny_q  <= {dny_q[NW-2:0], mby_neg};
      dz_q[0] <= z6_q;
      for (int k = 1; k < NW; k++) begin
        dz_q[k] <= dz_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- post-divide stage
  logic signed [QB+1:0]   vqx, vqy;
  logic signed [SATW-1:0] cxa, cya;
  logic                   vp_q, actp_q, errp_q;
  logic signed [CB-1:0]   px_q, py_q, zp_q;

  // Apply sign, add the center for projection
  always_comb begin
    vqx = $signed({2'b00, clamp_q(qx)});
    vqy = $signed({2'b00, clamp_q(qy)});
    if (dnx_q[NW-1]) begin
      vqx = -vqx;
    end
    if (dny_q[NW-1]) begin
      vqy = -vqy;
    end
    if (dact_q[NW-1] == ACT_PROJECT) begin
      cxa = SATW'($signed({1'b0, cx_q}));
      cya = SATW'($signed({1'b0, cy_q}));
    end else begin
      cxa = '0;
      cya = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= sat_cb(SATW'(vqx) + cxa);
      py_q   <= sat_cb(SATW'(vqy) + cya);
      zp_q   <= dz_q[NW-1];
      actp_q <= dact_q[NW-1];
      errp_q <= derr_q[NW-1];
    end
  end

  // ---------------------------------------------------------------- R * cam products
  logic signed [CB-1:0] camb [3];
  logic [PBW-1:0]       pb_mag [3][3];
  logic                 pb_neg [3][3];

  assign camb[0] = px_q;
  assign camb[1] = py_q;
  assign camb[2] = zp_q;

  for (genvar i = 0; i < 3; i++) begin : g_mulr_r
    for (genvar j = 0; j < 3; j++) begin : g_mulr_c
      ppu_mul #(.AW(RB), .BW(CB)) u_mulr (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (rm[i][j]),
        .b_i   (camb[j]),
        .mag_o (pb_mag[i][j]),
        .neg_o (pb_neg[i][j])
      );
    end
  end

  logic                 vm1_q, vm2_q, actm1_q, actm2_q, errm1_q, errm2_q;
  logic signed [CB-1:0] xm1_q, ym1_q, zm1_q, xm2_q, ym2_q, zm2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      actm1_q <= actp_q;
      errm1_q <= errp_q;
      xm1_q   <= px_q;
      ym1_q   <= py_q;
      zm1_q   <= zp_q;
      actm2_q <= actm1_q;
      errm2_q <= errm1_q;
      xm2_q   <= xm1_q;
      ym2_q   <= ym1_q;
      zm2_q   <= zm1_q;
    end
  end

  // ---------------------------------------------------------------- world point sum
  logic                  vu_q, actu_q, erru_q;
  logic signed [ACW-1:0] accu_q [3];
  logic signed [CB-1:0]  xu_q, yu_q, zu_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        accu_q[i] <= ACW'(tr_q[i])
                   + ACW'(term_b(pb_mag[i][0], pb_neg[i][0]))
                   + ACW'(term_b(pb_mag[i][1], pb_neg[i][1]))
                   + ACW'(term_b(pb_mag[i][2], pb_neg[i][2]));
      end
      actu_q <= actm2_q;
      erru_q <= errm2_q;
      xu_q   <= xm2_q;
      yu_q   <= ym2_q;
      zu_q   <= zm2_q;
    end
  end

  // Select the result word
  pp_out_t res;

  always_comb begin
    res.div_error = erru_q;
    if (erru_q) begin
      res.out_x = CMAX;
      res.out_y = CMAX;
      res.out_z = zu_q;
    end else if (actu_q == ACT_UNPROJECT) begin
      res.out_x = sat_cb(SATW'(accu_q[0]));
      res.out_y = sat_cb(SATW'(accu_q[1]));
      res.out_z = sat_cb(SATW'(accu_q[2]));
    end else begin
      res.out_x = xu_q;
      res.out_y = yu_q;
      res.out_z = zu_q;
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      dv_q  <= '0;
      vp_q  <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vu_q  <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      dv_q  <= {dv_q[NW-2:0], v6_q};
      vp_q  <= dv_q[NW-1];
      vm1_q <= vp_q;
      vm2_q <= vm1_q;
      vu_q  <= vm2_q;
    end
  end

  // ---------------------------------------------------------------- output buffer
  logic    wp_q, rp_q;
  pp_out_t fifo_q [2];

  assign push        = vu_q && en;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= res;
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overfilled");

  a_err_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_error |->
      out_data_o.out_x == CMAX && out_data_o.out_y == CMAX)
    else $error("error word without saturated x/y");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vu_q) && $stable(dv_q) && $stable(v1_q))
    else $error("pipeline moved while frozen");
`endif

endmodule

`default_nettype wire

FILE: rtl/ppu_mul.sv
`default_nettype none

// Two-stage signed multiplier: magnitude and sign out, product split in
// four partial products of half width.
module ppu_mul #(
  parameter int AW = 18,
  parameter int BW = 33
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic [AW+BW-1:0]     mag_o,
  output logic                 neg_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW-1:0]    am;
  logic [BW-1:0]    bm;
  logic [AL+BL-1:0] ll_d, ll_q;
  logic [AL+BH-1:0] lh_d, lh_q;
  logic [AH+BL-1:0] hl_d, hl_q;
  logic [AH+BH-1:0] hh_d, hh_q;
  logic             neg_q;
  logic [PW-1:0]    mag_d;

  // Take magnitudes and form the partial products
  always_comb begin
    am   = a_i[AW-1] ? unsigned'(-a_i) : unsigned'(a_i);
    bm   = b_i[BW-1] ? unsigned'(-b_i) : unsigned'(b_i);
    ll_d = am[AL-1:0] * bm[BL-1:0];
    lh_d = am[AL-1:0] * bm[BW-1:BL];
    hl_d = am[AW-1:AL] * bm[BL-1:0];
    hh_d = am[AW-1:AL] * bm[BW-1:BL];
  end

  // Combine the partial products
  always_comb begin
    mag_d = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= ll_d;
      lh_q  <= lh_d;
      hl_q  <= hl_d;
      hh_q  <= hh_d;
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
      mag_o <= mag_d;
      neg_o <= neg_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ppu_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
module ppu_div #(
  parameter int NW = 71,
  parameter int DW = 38
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q [NW-1];
  logic [DW-1:0] den_q [NW-1];
  logic [NW-1:0] num_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] num_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign num_in = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign num_in = num_q[k-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_in, num_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NW-2:0], ge};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = num_q[NW-1];

endmodule

`default_nettype wire
